// File: src/assert_macros.svh
// Assertion macros shared by the checker files.
// Every property samples on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/flwp_pkg.sv
// Shared types and constants for the flash write word packer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package flwp_pkg;

  localparam int SECTOR_BYTES = 4096;
  localparam int SECTOR_LOG2  = $clog2(SECTOR_BYTES);
  localparam int ADDR_W       = 24;
  localparam int SECTOR_W     = ADDR_W - SECTOR_LOG2;
  localparam int LIMIT_W      = 25;
  localparam int WORD_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int PEND_W       = 24;
  localparam int MAX_RESULTS  = 3;
  localparam int CFG_IDX_W    = 1;

  typedef enum logic [1:0] {
    CMD_ERASE = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ERROR = 2'd2,
    CMD_DONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    MODE_DATA = 1'b0,
    MODE_END  = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ADDRESS = 1'b0,
    REG_END_LIMIT     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    mode_t             mode;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    cmd_t              command;
    logic [ADDR_W-1:0] flash_address;
    logic [WORD_W-1:0] word_data;
    logic              last;
  } out_item_t;

  // All results of one request, in issue order.
  typedef struct packed {
    logic [1:0]                      count;
    out_item_t [MAX_RESULTS-1:0]     res;
  } bundle_t;

endpackage

`default_nettype wire

// File: src/flwp_core.sv
// Session state, configuration registers and per-request result generation.
// Depends on flwp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flwp_core (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       accept,
  input  flwp_pkg::in_item_t        item,
  input  wire                       cfg_we,
  input  wire [flwp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire [flwp_pkg::LIMIT_W-1:0]   cfg_wdata,
  output flwp_pkg::bundle_t         bundle
);
  import flwp_pkg::*;

  logic [ADDR_W-1:0]   start_r;
  logic [LIMIT_W-1:0]  limit_r;

  logic [ADDR_W-1:0]   wp_r, wp_nxt;
  logic [SECTOR_W-1:0] ets_r, ets_nxt;
  logic                any_r, any_nxt;
  logic [PEND_W-1:0]   pb_r, pb_nxt;
  logic [1:0]          pc_r, pc_nxt;
  logic                sess_r, sess_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      limit_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_START_ADDRESS: start_r <= cfg_wdata[ADDR_W-1:0];
        REG_END_LIMIT:     limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [ADDR_W-1:0]   wp_e;
    logic [SECTOR_W-1:0] ets_e;
    logic                any_e;
    logic [PEND_W-1:0]   pb_e;
    logic [1:0]          pc_e;
    logic                is_end;
    logic                do_word;
    logic                over;
    logic                need_erase;
    logic                did_erase;
    logic [SECTOR_W-1:0] sector;
    logic [WORD_W-1:0]   word;
    logic [ADDR_W-1:0]   wp_after;
    logic [LIMIT_W-1:0]  top;

    is_end = (item.mode == MODE_END);

    // A data byte with no open session starts from a fresh session.
    wp_e  = sess_r ? wp_r : {start_r[ADDR_W-1:2], 2'b00};
    ets_e = sess_r ? ets_r : '0;
    any_e = sess_r & any_r;
    pb_e  = sess_r ? pb_r : '0;
    pc_e  = sess_r ? pc_r : 2'd0;

    if (!is_end) begin
      word = {item.data_byte, pb_e};
    end else begin
      case (pc_e)
        2'd1:    word = {24'hFFFFFF, pb_e[7:0]};
        2'd2:    word = {16'hFFFF, pb_e[15:0]};
        default: word = {8'hFF, pb_e[23:0]};
      endcase
    end

    do_word    = (!is_end && pc_e == 2'd3) || (is_end && sess_r && pc_e != 2'd0);
    top        = {1'b0, wp_e} + LIMIT_W'(4);
    over       = (limit_r != '0) && (top > limit_r);
    sector     = wp_e[ADDR_W-1:SECTOR_LOG2];
    need_erase = !any_e || (sector > ets_e);
    did_erase  = do_word && !over && need_erase;
    wp_after   = (do_word && !over) ? wp_e + ADDR_W'(4) : wp_e;

    bundle = '0;
    if (do_word) begin
      if (over) begin
        bundle.res[bundle.count].command       = CMD_ERROR;
        bundle.res[bundle.count].flash_address = wp_e;
        bundle.count                           = bundle.count + 2'd1;
      end else begin
        if (need_erase) begin
          bundle.res[bundle.count].command       = CMD_ERASE;
          bundle.res[bundle.count].flash_address = {sector, {SECTOR_LOG2{1'b0}}};
          bundle.count                           = bundle.count + 2'd1;
        end
        bundle.res[bundle.count].command       = CMD_WRITE;
        bundle.res[bundle.count].flash_address = wp_e;
        bundle.res[bundle.count].word_data     = word;
        bundle.count                           = bundle.count + 2'd1;
      end
    end
    if (is_end) begin
      if (!sess_r) begin
        bundle.res[bundle.count].command       = CMD_ERROR;
        bundle.res[bundle.count].flash_address = wp_r;
        bundle.count                           = bundle.count + 2'd1;
      end else if (!(do_word && over)) begin
        bundle.res[bundle.count].command       = CMD_DONE;
        bundle.res[bundle.count].flash_address = wp_after;
        bundle.count                           = bundle.count + 2'd1;
      end
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      bundle.res[i].last = (2'(i) == bundle.count - 2'd1);
    end

    // End request with no session changes nothing.
    if (is_end && !sess_r) begin
      wp_nxt   = wp_r;
      ets_nxt  = ets_r;
      any_nxt  = any_r;
      pb_nxt   = pb_r;
      pc_nxt   = pc_r;
      sess_nxt = sess_r;
    end else begin
      wp_nxt   = wp_after;
      ets_nxt  = did_erase ? sector : ets_e;
      any_nxt  = did_erase | any_e;
      sess_nxt = !is_end;
      pb_nxt   = '0;
      pc_nxt   = 2'd0;
      if (!is_end && pc_e != 2'd3) begin
        pb_nxt = pb_e;
        case (pc_e)
          2'd0:    pb_nxt[7:0]   = item.data_byte;
          2'd1:    pb_nxt[15:8]  = item.data_byte;
          default: pb_nxt[23:16] = item.data_byte;
        endcase
        pc_nxt = pc_e + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      ets_r  <= '0;
      any_r  <= 1'b0;
      pb_r   <= '0;
      pc_r   <= 2'd0;
      sess_r <= 1'b0;
    end else if (accept) begin
      wp_r   <= wp_nxt;
      ets_r  <= ets_nxt;
      any_r  <= any_nxt;
      pb_r   <= pb_nxt;
      pc_r   <= pc_nxt;
      sess_r <= sess_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/flwp_outq.sv
// Result buffer for one request plus the output register that drives the result port.
// Depends on flwp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flwp_outq (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  flwp_pkg::bundle_t   bundle,
  output logic                ready,
  output logic                out_valid,
  input  wire                 out_stall,
  output flwp_pkg::out_item_t out_data
);
  import flwp_pkg::*;

  out_item_t [MAX_RESULTS-1:0] buf_r;
  logic [1:0]                  rem_r;
  logic [1:0]                  idx_r;
  logic                        ov_r;
  out_item_t                   od_r;
  logic                        o_free;
  logic                        move;

  assign o_free    = !ov_r || !out_stall;
  assign move      = (rem_r != 2'd0) && o_free;
  // Take a new request once the buffer is empty or hands off its final result now.
  assign ready     = (rem_r == 2'd0) || (rem_r == 2'd1 && o_free);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      rem_r <= bundle.count;
      idx_r <= 2'd0;
    end else if (move) begin
      rem_r <= rem_r - 2'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= bundle.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (move) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      od_r <= buf_r[idx_r];
    end
  end

endmodule

`default_nettype wire

// File: src/flash_write_word_packer.sv
// Top level of the flash write word packer: byte requests in, flash commands out.
// Depends on flwp_pkg, flwp_core and flwp_outq.
//
//   port group   direction  handshake        payload
//   in_*         input      valid / stall    in_item_t  (mode, data_byte)
//   out_*        output     valid / stall    out_item_t (command, address, word, last)
//   cfg_*        input      valid / ready    register index, 25-bit write data
//
// One request is taken per cycle while in_stall is low; its zero to three results are
// computed in that cycle and held in a three-entry result buffer. The result port issues
// one result per cycle while out_stall is low. Each result passes from the result buffer
// through the output register. Reset is synchronous and clears all control state; no clear
// pass is needed. cfg_ready is always high. in_stall rises when the buffer still holds
// results that cannot drain this cycle.
`timescale 1ns / 1ps
`default_nettype none

module flash_write_word_packer (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  flwp_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output flwp_pkg::out_item_t           out_data,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [flwp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [flwp_pkg::LIMIT_W-1:0]   cfg_data
);
  import flwp_pkg::*;

  logic    accept;
  logic    q_ready;
  bundle_t bundle;

  assign cfg_ready = 1'b1;
  assign in_stall  = !q_ready;
  assign accept    = in_valid && q_ready;

  flwp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .bundle    (bundle)
  );

  flwp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .bundle    (bundle),
    .ready     (q_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: src/flwp_checker.sv
// Port-level checks on the flash write word packer, bound to the top level.
// Depends on flwp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module flwp_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           out_valid,
  input wire                           out_stall,
  input flwp_pkg::out_item_t           out_data
);
  import flwp_pkg::*;

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
               "stalled result changed")
  `ASSERT_CLK(a_erase_not_last, !(out_valid && out_data.command == CMD_ERASE) ||
              !out_data.last, "erase marked as last result")
  `ASSERT_CLK(a_done_last, !(out_valid && out_data.command == CMD_DONE) || out_data.last,
              "done not marked as last result")
  `ASSERT_CLK(a_write_aligned, !(out_valid && out_data.command == CMD_WRITE) ||
              out_data.flash_address[1:0] == 2'b00, "write address not word aligned")
  `ASSERT_CLK(a_erase_aligned, !(out_valid && out_data.command == CMD_ERASE) ||
              out_data.flash_address[SECTOR_LOG2-1:0] == '0,
              "erase address not on a sector boundary")

endmodule

bind flash_write_word_packer flwp_checker u_flwp_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for flash_write_word_packer: byte images and end requests go in,
// and every erase, write, error and done command is checked against an in-bench model.
// Depends on flwp_pkg and flash_write_word_packer only.
module testbench;
  import flwp_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 220;
  localparam logic [BYTE_W-1:0]  PAD_BYTE  = 8'hFF;
  localparam logic [ADDR_W-1:0]  WORD_MASK = 24'hFFFFFC;
  localparam logic [ADDR_W-1:0]  ADDR_TOP  = 24'hFFFFFF;
  localparam logic [LIMIT_W-1:0] LIMIT_TOP = 25'h1000000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_reg_t           cfg_index = REG_START_ADDRESS;
  logic [LIMIT_W-1:0] cfg_data  = '0;

  flash_write_word_packer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Packer model: registers, session state and the commands still owed.
  logic [ADDR_W-1:0]   cfg_start = '0;
  logic [LIMIT_W-1:0]  cfg_limit = '0;
  logic [ADDR_W-1:0]   wr_ptr = '0;
  logic [SECTOR_W-1:0] erased_sector = '0;
  logic                erased_any = 1'b0;
  logic [PEND_W-1:0]   pend_bytes = '0;
  logic [1:0]          pend_cnt = '0;
  logic                image_open = 1'b0;
  out_item_t           step_cmds[$];
  out_item_t           expected_cmds[$];

  in_item_t    pending_requests[$];
  int unsigned queued_total = 0;
  int unsigned taken_total = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  out_item_t   want_cmd;

  function automatic void emit_cmd(cmd_t cmd, logic [ADDR_W-1:0] addr,
                                   logic [WORD_W-1:0] word);
    out_item_t r;
    r.command       = cmd;
    r.flash_address = addr;
    r.word_data     = word;
    r.last          = 1'b0;
    step_cmds.push_back(r);
  endfunction

  // Returns 0 when the word is refused for passing the end limit.
  function automatic bit place_word(logic [WORD_W-1:0] word);
    logic [ADDR_W-1:0]   tail;
    logic [SECTOR_W-1:0] sector;
    if (cfg_limit != '0 && ({1'b0, wr_ptr} + LIMIT_W'(4)) > cfg_limit) begin
      emit_cmd(CMD_ERROR, wr_ptr, '0);
      return 1'b0;
    end
    // the sector is taken from the word's last byte
    tail   = wr_ptr + ADDR_W'(3);
    sector = tail[ADDR_W-1:SECTOR_LOG2];
    if (!erased_any || sector > erased_sector) begin
      emit_cmd(CMD_ERASE, {sector, {SECTOR_LOG2{1'b0}}}, '0);
      erased_sector = sector;
      erased_any    = 1'b1;
    end
    emit_cmd(CMD_WRITE, wr_ptr, word);
    wr_ptr = wr_ptr + ADDR_W'(4);
    return 1'b1;
  endfunction

  function automatic void predict_commands(in_item_t req);
    logic [WORD_W-1:0] word;
    logic              ok;
    out_item_t         r;
    step_cmds.delete();
    if (req.mode == MODE_DATA) begin
      if (!image_open) begin
        image_open    = 1'b1;
        wr_ptr        = cfg_start & WORD_MASK;
        erased_any    = 1'b0;
        erased_sector = '0;
        pend_bytes    = '0;
        pend_cnt      = '0;
      end
      if (pend_cnt != 2'd3) begin
        pend_bytes[8*pend_cnt +: 8] = req.data_byte;
        pend_cnt++;
      end else begin
        void'(place_word({req.data_byte, pend_bytes}));
        pend_bytes = '0;
        pend_cnt   = '0;
      end
    end else if (!image_open) begin
      emit_cmd(CMD_ERROR, wr_ptr, '0);
    end else begin
      ok = 1'b1;
      if (pend_cnt != 2'd0) begin
        // pad the missing upper bytes as erased flash
        word = {PAD_BYTE, pend_bytes};
        for (int i = pend_cnt; i < 3; i++) word[8*i +: 8] = PAD_BYTE;
        ok = place_word(word);
      end
      if (ok) begin
        emit_cmd(CMD_DONE, wr_ptr, '0);
      end
      pend_bytes = '0;
      pend_cnt   = '0;
      image_open = 1'b0;
    end
    foreach (step_cmds[i]) begin
      r      = step_cmds[i];
      r.last = (i == step_cmds.size() - 1);
      expected_cmds.push_back(r);
    end
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return PAD_BYTE;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic queue_req(mode_t mode, logic [BYTE_W-1:0] data_byte);
    in_item_t r;
    r.mode      = mode;
    r.data_byte = data_byte;
    pending_requests.push_back(r);
    queued_total++;
  endtask

  task automatic wait_drained();
    while (taken_total != queued_total || expected_cmds.size() != 0) @(posedge clk);
    // data bytes give no command, so give the last of them time to settle
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == REG_START_ADDRESS) begin
      cfg_start = value[ADDR_W-1:0];
    end else begin
      cfg_limit = value;
    end
    cfg_valid <= 1'b0;
  endtask

  // Request driver: hold a stalled request, otherwise idle or load the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_commands(in_data);
        taken_total++;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_requests.pop_front();
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Command monitor and receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected command %0d addr %h data %h last %b", out_data.command,
                     out_data.flash_address, out_data.word_data, out_data.last);
          end
          mismatches++;
        end else begin
          want_cmd = expected_cmds.pop_front();
          if (out_data.command !== want_cmd.command ||
              out_data.flash_address !== want_cmd.flash_address ||
              out_data.word_data !== want_cmd.word_data ||
              out_data.last !== want_cmd.last) begin
            if (mismatches < 10) begin
              $display("mismatch: expected cmd %0d addr %h data %h last %b, got cmd %0d addr %h data %h last %b",
                       want_cmd.command, want_cmd.flash_address, want_cmd.word_data,
                       want_cmd.last, out_data.command, out_data.flash_address,
                       out_data.word_data, out_data.last);
            end
            mismatches++;
          end
        end
      end
      if (stall_left == 0) stall_left = pick_gap(recv_calm);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned        target;
    int unsigned        phase_items;
    int unsigned        nbytes;
    logic [ADDR_W-1:0]  start;
    logic [LIMIT_W-1:0] limit;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // end request with no session open, then words, a padded flush and a bare done
    queue_req(MODE_END, 8'h00);
    queue_req(MODE_DATA, 8'h00);
    queue_req(MODE_DATA, 8'hFF);
    queue_req(MODE_DATA, 8'h80);
    queue_req(MODE_DATA, 8'h01);
    queue_req(MODE_DATA, 8'h7F);
    queue_req(MODE_DATA, 8'h55);
    queue_req(MODE_END, 8'hFF);
    queue_req(MODE_DATA, 8'hAA);
    queue_req(MODE_DATA, 8'hBB);
    queue_req(MODE_DATA, 8'hCC);
    queue_req(MODE_DATA, 8'hDD);
    queue_req(MODE_END, 8'h5A);
    wait_drained();

    // unaligned start just below a sector edge, limit two words later
    write_reg(REG_START_ADDRESS, 25'h001FFF);
    write_reg(REG_END_LIMIT, 25'h002004);
    for (int i = 0; i < 13; i++) queue_req(MODE_DATA, BYTE_W'(8'h10 + i));
    queue_req(MODE_END, 8'hA5);

    target = queued_total + RANDOM_ITEMS;
    for (int phase = 0; queued_total < target; phase++) begin
      wait_drained();
      if (phase == 0) begin
        start = ADDR_TOP;
        limit = LIMIT_TOP;
      end else if (phase == 1) begin
        start = '0;
        limit = '0;
      end else begin
        case ($urandom_range(0, 3))
          0: start = ADDR_W'($urandom_range(0, 255));
          1: start = ADDR_TOP - ADDR_W'($urandom_range(0, 64));
          2: start = ADDR_W'($urandom_range(1, 4095) << SECTOR_LOG2) -
                     ADDR_W'($urandom_range(0, 40));
          default: start = ADDR_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0: limit = '0;
          1: limit = LIMIT_TOP;
          2: limit = {1'b0, start & WORD_MASK} + LIMIT_W'($urandom_range(0, 64));
          3: limit = LIMIT_W'($urandom_range(1, 16));
          default: limit = LIMIT_W'($urandom_range(0, 32'h1000000));
        endcase
      end
      write_reg(REG_START_ADDRESS, {1'b0, start});
      write_reg(REG_END_LIMIT, limit);
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);

      phase_items = 0;
      while (phase_items < 40) begin
        // stray end request as noise
        if ($urandom_range(0, 7) == 0) begin
          queue_req(MODE_END, rand_byte());
          phase_items++;
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: nbytes = $urandom_range(0, 12);
          6, 7, 8: nbytes = 4 * $urandom_range(1, 4);
          default: nbytes = $urandom_range(20, 40);
        endcase
        for (int i = 0; i < nbytes; i++) queue_req(MODE_DATA, rand_byte());
        phase_items += nbytes;
        // now and then leave the session open across the register writes
        if ($urandom_range(0, 4) != 0) begin
          queue_req(MODE_END, rand_byte());
          phase_items++;
        end
      end
    end
    queue_req(MODE_END, rand_byte());

    wait_drained();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
